>>> hdl/lrsn_pkg.sv
package lrsn_pkg;

    // Ring geometry and record layout
    localparam int SLOTS        = 256;
    localparam int RECORD_BYTES = 32;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W        = $clog2(RECORD_BYTES);
    localparam int COUNT_CAP    = (SLOTS > 511) ? 511 : SLOTS;

    // Byte offsets of the header fields inside a record
    localparam int OFS_MAGIC    = 0;
    localparam int OFS_VERSION  = 2;
    localparam int OFS_SEQ      = 4;

    // CRC-8, MSB first, no reflection, no final xor
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Register reset values
    localparam logic [15:0] MAGIC_RESET   = 16'hA55A;
    localparam logic [7:0]  VERSION_RESET = 8'h01;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } byte_item_t;

    typedef struct packed {
        logic        record_valid;
        logic [7:0]  record_slot;
        logic [31:0] record_sequence;
        logic [8:0]  good_count;
        logic        newest_found;
        logic [7:0]  latest_slot;
        logic [7:0]  next_slot;
        logic [31:0] next_sequence;
    } result_item_t;

    // One byte step as seen by the scan tracker
    typedef struct packed {
        logic        step;
        logic        restart;
        logic        done;
        logic        ok;
        logic [31:0] seq;
    } rec_event_t;

    // Scan status after the step, already in output widths
    typedef struct packed {
        logic [7:0]  record_slot;
        logic [8:0]  good_count;
        logic        newest_found;
        logic [7:0]  latest_slot;
        logic [7:0]  next_slot;
        logic [31:0] next_sequence;
    } scan_status_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Low 8 bits of a slot index
    function automatic logic [7:0] slot_to_byte(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+7:0] w;
        w = {8'b0, s};
        return w[7:0];
    endfunction

endpackage

>>> hdl/lrsn_tracker.sv
module lrsn_tracker
    import lrsn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rec_event_t   evt,
    output scan_status_t status
);

    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [8:0]        total_reg, total_next;
    logic [31:0]       newest_seq_reg, newest_seq_next;
    logic [SLOT_W-1:0] latest_slot_reg, latest_slot_next;

    logic [SLOT_W-1:0] base_slot;
    logic [8:0]        base_total;
    logic [31:0]       base_seq;
    logic [SLOT_W-1:0] base_latest_slot;
    logic [31:0]       diff;
    logic              newer;
    logic [SLOT_W-1:0] after_newest;
    logic [31:0]       seq_plus;

    // Restart clears the scan ahead of the byte it comes with
    always_comb
    begin
        base_slot        = evt.restart ? '0 : cur_slot_reg;
        base_total       = evt.restart ? '0 : total_reg;
        base_seq         = evt.restart ? '0 : newest_seq_reg;
        base_latest_slot = evt.restart ? '0 : latest_slot_reg;
    end

    // Newer by wrapping signed difference; equal sequences keep the older slot
    assign diff  = evt.seq - base_seq;
    assign newer = (base_seq == 32'd0) || ((diff != 32'd0) && !diff[31]);

    always_comb
    begin
        cur_slot_next    = cur_slot_reg;
        total_next       = total_reg;
        newest_seq_next  = newest_seq_reg;
        latest_slot_next = latest_slot_reg;
        if (evt.step)
        begin
            cur_slot_next    = base_slot;
            total_next       = base_total;
            newest_seq_next  = base_seq;
            latest_slot_next = base_latest_slot;
            if (evt.done)
            begin
                cur_slot_next = (base_slot == SLOT_W'(SLOTS - 1)) ? '0 : base_slot + 1'b1;
                if (evt.ok)
                begin
                    if (base_total < 9'(COUNT_CAP))
                        total_next = base_total + 9'd1;
                    if (newer)
                    begin
                        newest_seq_next  = evt.seq;
                        latest_slot_next = base_slot;
                    end
                end
            end
        end
    end

    // Status as reported with the finished record
    assign after_newest = (latest_slot_next == SLOT_W'(SLOTS - 1)) ? '0
                                                                   : latest_slot_next + 1'b1;
    assign seq_plus     = newest_seq_next + 32'd1;

    always_comb
    begin
        status.record_slot   = slot_to_byte(base_slot);
        status.good_count    = total_next;
        status.newest_found  = (newest_seq_next != 32'd0);
        status.latest_slot   = slot_to_byte(latest_slot_next);
        status.next_slot     = status.newest_found ? slot_to_byte(after_newest) : 8'd0;
        status.next_sequence = (seq_plus == 32'd0) ? 32'd1 : seq_plus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg    <= '0;
            total_reg       <= '0;
            newest_seq_reg  <= '0;
            latest_slot_reg <= '0;
        end
        else
        begin
            cur_slot_reg    <= cur_slot_next;
            total_reg       <= total_next;
            newest_seq_reg  <= newest_seq_next;
            latest_slot_reg <= latest_slot_next;
        end
    end

`ifndef SYNTHESIS
    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 9'(COUNT_CAP))
        else $error("valid count above cap");

    a_none_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (newest_seq_reg == 32'd0) |-> (latest_slot_reg == '0))
        else $error("newest slot set without a newest record");

    a_valid_sets_newest: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.step && evt.done && evt.ok) |=> (newest_seq_reg != 32'd0))
        else $error("valid record left no newest sequence");
`endif

endmodule

>>> hdl/log_record_scan_newest.sv
// Recovery scan over a ring of fixed-size log records. Record bytes stream in one per
// item, slot after slot; each record's last byte is its stored CRC-8 (poly 0x07, init 0)
// over the bytes before it. After every last byte one result comes out: whether magic,
// version, non-zero sequence and CRC matched, plus the running valid count, the newest
// record (by wrapping signed sequence difference) and the slot and sequence to append
// next. restart on an item makes that byte byte 0 of slot 0 and clears the scan.
// Rate: one byte per clock while results are read. An accepted byte waits in the input
// register while the byte update (CRC step, header capture, newest compare) runs into
// the result register, so a result is shown once its last byte's update is written there.
// Only a record's last byte waits, and only while the previous result is still held
// unread. Configuration writes always complete without waiting.
module log_record_scan_newest
    import lrsn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  byte_item_t            byte_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_item_t          result_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             in_valid_reg;
    byte_item_t       in_item_reg;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [15:0]      magic_reg, magic_next;
    logic [7:0]       version_reg, version_next;
    logic [31:0]      seq_reg, seq_next;
    logic [15:0]      exp_magic_reg;
    logic [7:0]       exp_version_reg;
    logic             result_valid_reg;
    result_item_t     result_item_reg;

    logic [POS_W-1:0] pos;
    logic [7:0]       crc_base;
    logic [7:0]       b;
    logic             is_last;
    logic             out_free;
    logic             advance;
    logic             rec_ok;
    rec_event_t       evt;
    scan_status_t     status;

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // Byte position and CRC as seen after an optional restart
    assign b        = in_item_reg.data_byte;
    assign pos      = in_item_reg.restart ? '0 : byte_pos_reg;
    assign crc_base = in_item_reg.restart ? '0 : crc_reg;
    assign is_last  = (pos == POS_W'(RECORD_BYTES - 1));

    // Flow control: only a last byte needs room in the result register
    assign out_free   = !result_valid_reg || result_ready;
    assign advance    = in_valid_reg && (!is_last || out_free);
    assign byte_ready = !in_valid_reg || advance;

    // Header capture and CRC step
    always_comb
    begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        seq_next      = seq_reg;
        byte_pos_next = is_last ? '0 : pos + 1'b1;
        crc_next      = is_last ? 8'd0 : crc8_byte(crc_base, b);
        if (pos == POS_W'(OFS_MAGIC))
            magic_next[7:0] = b;
        if (pos == POS_W'(OFS_MAGIC + 1))
            magic_next[15:8] = b;
        if (pos == POS_W'(OFS_VERSION))
            version_next = b;
        if (pos >= POS_W'(OFS_SEQ) && pos < POS_W'(OFS_SEQ + 4))
            seq_next[8 * pos[1:0] +: 8] = b;
    end

    assign rec_ok = (magic_reg == exp_magic_reg) && (version_reg == exp_version_reg) &&
                    (seq_reg != 32'd0) && (crc_base == b);

    always_comb
    begin
        evt.step    = advance;
        evt.restart = in_item_reg.restart;
        evt.done    = is_last;
        evt.ok      = rec_ok;
        evt.seq     = seq_reg;
    end

    lrsn_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .status (status)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= MAGIC_RESET;
            exp_version_reg <= VERSION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAGIC:   exp_magic_reg   <= cfg_data;
                REG_VERSION: exp_version_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_item_reg <= byte_item;
    end

    // Per-record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            crc_reg      <= '0;
        end
        else if (advance)
        begin
            byte_pos_reg <= byte_pos_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
            seq_reg     <= seq_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance && is_last)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            result_item_reg.record_valid    <= rec_ok;
            result_item_reg.record_slot     <= status.record_slot;
            result_item_reg.record_sequence <= seq_reg;
            result_item_reg.good_count      <= status.good_count;
            result_item_reg.newest_found    <= status.newest_found;
            result_item_reg.latest_slot     <= status.latest_slot;
            result_item_reg.next_slot       <= status.next_slot;
            result_item_reg.next_sequence   <= status.next_sequence;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= POS_W'(RECORD_BYTES - 1))
        else $error("byte position past record end");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(advance && is_last))
        else $error("result without a finished record");

    a_valid_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_item_reg.record_valid) |->
            (result_item_reg.newest_found && (result_item_reg.good_count != 9'd0)))
        else $error("valid record not reflected in scan status");
`endif

endmodule
